// ----- rtl/core/flj_pkg.sv -----
package flj_pkg;

  localparam int FLOW_IN_W = 4;
  localparam int SEQ_W     = 32;
  localparam int LEN_W     = 16;
  localparam int SECS_W    = 32;
  localparam int USECS_W   = 20;
  localparam int CNT_W     = 32;
  localparam int BYTES_W   = 48;
  localparam int DELAY_W   = 64;
  localparam int TRANSIT_W = 48;
  localparam int JIT_W     = 50;

  localparam int SDIFF_W   = SECS_W + 1;
  localparam int UDIFF_W   = USECS_W + 1;
  localparam int USCALE_W  = 21;
  localparam int PROD_W    = SDIFF_W + USCALE_W;
  localparam int SUM_W     = PROD_W + 1;

  localparam logic signed [USCALE_W-1:0] USEC_PER_SEC = 21'sd1000000;

  localparam int JIT_SHIFT = 4;
  localparam int JIT_ROUND = 8;

  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;
  localparam int Q_CNT_W   = 3;

  typedef struct packed {
    logic [FLOW_IN_W-1:0]        flow;
    logic [SEQ_W-1:0]            seq;
    logic [LEN_W-1:0]            len;
    logic signed [TRANSIT_W-1:0] transit;
  } flj_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]            top;
    logic [CNT_W-1:0]            loss;
    logic [CNT_W-1:0]            reord;
    logic [CNT_W-1:0]            pkts;
    logic [BYTES_W-1:0]          bytes;
    logic signed [DELAY_W-1:0]   delay;
    logic signed [TRANSIT_W-1:0] last;
    logic [JIT_W-1:0]            jitter;
  } flj_stats_t;

endpackage

// ----- rtl/core/flj_in_if.sv -----
interface flj_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  flow_index;
  logic [31:0] sequence_req;
  logic [15:0] length_bytes;
  logic [31:0] sent_secs;
  logic [19:0] sent_usecs;
  logic [31:0] arrival_secs;
  logic [19:0] arrival_usecs;

  modport source (
    output valid, flow_index, sequence_req, length_bytes, sent_secs, sent_usecs,
           arrival_secs, arrival_usecs,
    input  ready
  );

  modport sink (
    input  valid, flow_index, sequence_req, length_bytes, sent_secs, sent_usecs,
           arrival_secs, arrival_usecs,
    output ready
  );
endinterface

// ----- rtl/core/flj_out_if.sv -----
interface flj_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         flow_echo;
  logic [31:0]        highest_sequence;
  logic [31:0]        lost_packets;
  logic [31:0]        reordered_packets;
  logic [31:0]        packets_received;
  logic [47:0]        bytes_total;
  logic signed [63:0] delay_sum_us;
  logic [49:0]        jitter_q4_us;

  modport source (
    output valid, flow_echo, highest_sequence, lost_packets, reordered_packets,
           packets_received, bytes_total, delay_sum_us, jitter_q4_us,
    input  ready
  );

  modport sink (
    input  valid, flow_echo, highest_sequence, lost_packets, reordered_packets,
           packets_received, bytes_total, delay_sum_us, jitter_q4_us,
    output ready
  );
endinterface

// ----- rtl/core/flj_front.sv -----
module flj_front #(
  parameter int NUM_FLOWS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  flj_in_if.sink            in_pkt,
  output logic              push_valid,
  input  logic              push_ready,
  output flj_pkg::flj_item_t push_item
);
  import flj_pkg::*;

  logic                        accept;
  logic                        in_range;
  logic                        f1_v_r;
  logic                        f1_v_nxt;
  logic [FLOW_IN_W-1:0]        f1_flow_r;
  logic [SEQ_W-1:0]            f1_seq_r;
  logic [LEN_W-1:0]            f1_len_r;
  logic signed [PROD_W-1:0]    f1_prod_r;
  logic signed [UDIFF_W-1:0]   f1_udiff_r;
  logic signed [SDIFF_W-1:0]   sdiff;
  logic signed [UDIFF_W-1:0]   udiff;
  logic signed [SUM_W-1:0]     tsum;
  logic signed [TRANSIT_W-1:0] transit;

  assign in_pkt.ready = !f1_v_r || push_ready;
  assign accept       = in_pkt.valid && in_pkt.ready;
  assign in_range     = {{(32-FLOW_IN_W){1'b0}}, in_pkt.flow_index} < 32'(NUM_FLOWS);

  assign sdiff = $signed({1'b0, in_pkt.arrival_secs}) - $signed({1'b0, in_pkt.sent_secs});
  assign udiff = $signed({1'b0, in_pkt.arrival_usecs}) - $signed({1'b0, in_pkt.sent_usecs});

  // drop packets of flows outside the table at the door
  assign f1_v_nxt = (accept && in_range) || (f1_v_r && !push_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else begin
      f1_v_r <= f1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_flow_r  <= in_pkt.flow_index;
      f1_seq_r   <= in_pkt.sequence_req;
      f1_len_r   <= in_pkt.length_bytes;
      f1_prod_r  <= PROD_W'(sdiff) * PROD_W'(USEC_PER_SEC);
      f1_udiff_r <= udiff;
    end
  end

  assign tsum = SUM_W'(f1_prod_r) + SUM_W'(f1_udiff_r);

  // clamp transit to the signed 48-bit range
  always_comb begin
    if ((&tsum[SUM_W-1:TRANSIT_W-1]) || !(|tsum[SUM_W-1:TRANSIT_W-1])) begin
      transit = tsum[TRANSIT_W-1:0];
    end else if (tsum[SUM_W-1]) begin
      transit = {1'b1, {(TRANSIT_W-1){1'b0}}};
    end else begin
      transit = {1'b0, {(TRANSIT_W-1){1'b1}}};
    end
  end

  assign push_valid        = f1_v_r;
  assign push_item.flow    = f1_flow_r;
  assign push_item.seq     = f1_seq_r;
  assign push_item.len     = f1_len_r;
  assign push_item.transit = transit;

endmodule

// ----- rtl/core/flj_queue.sv -----
module flj_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  flj_pkg::flj_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output flj_pkg::flj_item_t pop_item
);
  import flj_pkg::*;

  flj_item_t          q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r;
  logic [Q_CNT_W-1:0] cnt_nxt;
  logic               push;
  logic               pop;

  assign push_ready = cnt_r != Q_CNT_W'(Q_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- rtl/core/flj_back.sv -----
module flj_back #(
  parameter int NUM_FLOWS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  flj_pkg::flj_item_t pop_item,
  flj_out_if.source          out_stats
);
  import flj_pkg::*;

  localparam int FLOW_W = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
  localparam int EXT_W  = FLOW_IN_W + FLOW_W;

  flj_stats_t                  mem [NUM_FLOWS];
  logic [NUM_FLOWS-1:0]        seen_r;

  logic                        pop;
  logic [EXT_W-1:0]            pop_ext;
  logic [FLOW_W-1:0]           pop_idx;
  logic                        fwd_hit;

  logic                        s1_v_r;
  logic                        s1_v_nxt;
  logic                        s1_move;
  flj_item_t                   s1_item_r;
  logic [FLOW_W-1:0]           s1_idx_r;
  flj_stats_t                  rd_ent_r;
  logic                        rd_seen_r;

  logic                        s2_v_r;
  logic                        s2_v_nxt;
  logic                        s2_done;
  logic [FLOW_W-1:0]           s2_idx_r;
  logic [FLOW_IN_W-1:0]        s2_flow_r;
  flj_stats_t                  s2_ent_r;
  logic [JIT_W-1:0]            s2_jmr_r;
  logic signed [TRANSIT_W:0]   s2_diff_r;

  logic                        out_v_r;
  logic                        out_v_nxt;
  logic [FLOW_IN_W-1:0]        out_flow_r;
  flj_stats_t                  out_ent_r;

  flj_stats_t                  ent;
  flj_stats_t                  upd;
  logic                        seq_fwd;
  logic [CNT_W-1:0]            gap;
  logic [CNT_W:0]              loss_sum;
  logic [BYTES_W:0]            bytes_sum;
  logic signed [TRANSIT_W-1:0] last_eff;
  logic signed [TRANSIT_W:0]   diff;
  logic [JIT_W:0]              jr;
  logic [JIT_W-1:0]            jmr;

  logic [TRANSIT_W:0]          dabs;
  logic [JIT_W:0]              jsum;
  flj_stats_t                  wr_ent;

  assign s2_done   = s2_v_r && (!out_v_r || out_stats.ready);
  assign s1_move   = s1_v_r && (!s2_v_r || s2_done);
  assign pop_ready = !s1_v_r && (!s2_v_r || s2_done);
  assign pop       = pop_valid && pop_ready;
  assign pop_ext   = EXT_W'(pop_item.flow);
  assign pop_idx   = pop_ext[FLOW_W-1:0];
  // bypass the entry written on the same edge as the read
  assign fwd_hit   = s2_done && (s2_idx_r == pop_idx);

  assign s1_v_nxt  = pop || (s1_v_r && !s1_move);
  assign s2_v_nxt  = s1_move || (s2_v_r && !s2_done);
  assign out_v_nxt = s2_done || (out_v_r && !out_stats.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      seen_r  <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
      if (s2_done) begin
        seen_r[s2_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_item_r <= pop_item;
      s1_idx_r  <= pop_idx;
      rd_ent_r  <= fwd_hit ? wr_ent : mem[pop_idx];
      rd_seen_r <= fwd_hit || seen_r[pop_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (s2_done) begin
      mem[s2_idx_r] <= wr_ent;
    end
  end

  always_comb begin
    ent       = rd_seen_r ? rd_ent_r : '0;
    seq_fwd   = s1_item_r.seq > ent.top;
    gap       = s1_item_r.seq + ~ent.top;
    loss_sum  = {1'b0, ent.loss} + {1'b0, gap};
    bytes_sum = {1'b0, ent.bytes} + (BYTES_W+1)'(s1_item_r.len);
    last_eff  = rd_seen_r ? rd_ent_r.last : s1_item_r.transit;
    diff      = (TRANSIT_W+1)'(s1_item_r.transit) - (TRANSIT_W+1)'(last_eff);
    jr        = ({1'b0, ent.jitter} + (JIT_W+1)'(JIT_ROUND)) >> JIT_SHIFT;
    jmr       = ent.jitter - jr[JIT_W-1:0];

    upd        = ent;
    if (seq_fwd) begin
      upd.top  = s1_item_r.seq;
      upd.loss = loss_sum[CNT_W] ? '1 : loss_sum[CNT_W-1:0];
    end else begin
      upd.reord = (&ent.reord) ? ent.reord : ent.reord + 1'b1;
      upd.loss  = (ent.loss != '0) ? ent.loss - 1'b1 : '0;
    end
    upd.pkts   = (&ent.pkts) ? ent.pkts : ent.pkts + 1'b1;
    upd.bytes  = bytes_sum[BYTES_W] ? '1 : bytes_sum[BYTES_W-1:0];
    upd.delay  = ent.delay + DELAY_W'(s1_item_r.transit);
    upd.last   = s1_item_r.transit;
    upd.jitter = ent.jitter;
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_idx_r  <= s1_idx_r;
      s2_flow_r <= s1_item_r.flow;
      s2_ent_r  <= upd;
      s2_jmr_r  <= jmr;
      s2_diff_r <= diff;
    end
  end

  always_comb begin
    dabs          = s2_diff_r[TRANSIT_W] ? $unsigned(-s2_diff_r) : $unsigned(s2_diff_r);
    jsum          = {1'b0, s2_jmr_r} + (JIT_W+1)'(dabs);
    wr_ent        = s2_ent_r;
    wr_ent.jitter = jsum[JIT_W] ? '1 : jsum[JIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (s2_done) begin
      out_flow_r <= s2_flow_r;
      out_ent_r  <= wr_ent;
    end
  end

  assign out_stats.valid             = out_v_r;
  assign out_stats.flow_echo         = out_flow_r;
  assign out_stats.highest_sequence  = out_ent_r.top;
  assign out_stats.lost_packets      = out_ent_r.loss;
  assign out_stats.reordered_packets = out_ent_r.reord;
  assign out_stats.packets_received  = out_ent_r.pkts;
  assign out_stats.bytes_total       = out_ent_r.bytes;
  assign out_stats.delay_sum_us      = out_ent_r.delay;
  assign out_stats.jitter_q4_us      = out_ent_r.jitter;

endmodule

// ----- rtl/core/flow_loss_jitter_stats.sv -----
// Per-flow receive statistics: loss, reorder, packet and byte counts,
// summed transit delay and smoothed interarrival jitter.
// in_pkt carries one packet per transaction (flow, sequence, length, sent and
// arrival timestamps); out_stats carries the updated statistics of that flow,
// one transaction per packet. Packets of flows at or above NUM_FLOWS are
// accepted and dropped without a result.
// A packet accepted on in_pkt passes the front register, the queue, the
// read stage, the update stage and the output register. The back end takes
// no new packet while one is in its read stage, set by the read-modify-write
// of the per-flow statistics memory (read, update, write back with bypass).
// The front computes transit time and feeds a 4-entry queue, so in_pkt keeps
// being taken while a result waits on out_stats.
// Reset: all flows read as zero at once through per-flow valid bits; no
// clearing pass, the block accepts packets right after reset.
// When out_stats stalls, the result holds, the back end stops, the queue
// fills and in_pkt.ready then falls.
module flow_loss_jitter_stats #(
  parameter int NUM_FLOWS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  flj_in_if.sink    in_pkt,
  flj_out_if.source out_stats
);
  import flj_pkg::*;

  logic      push_valid;
  logic      push_ready;
  flj_item_t push_item;
  logic      pop_valid;
  logic      pop_ready;
  flj_item_t pop_item;

  flj_front #(
    .NUM_FLOWS (NUM_FLOWS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_pkt     (in_pkt),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  flj_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  flj_back #(
    .NUM_FLOWS (NUM_FLOWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_stats (out_stats)
  );

endmodule
